/* design/lssb_pkg.sv */
package lssb_pkg;

   localparam logic [7:0] FULL_SCALE = 8'd255;
   localparam logic [9:0] SPREAD_MAX = 10'd1020;
   localparam logic [9:0] SPREAD_RESET = 10'd255;
   localparam logic [1:0] LAST_CH = 2'd2;

   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic        op;
      logic [15:0] position;
      logic [23:0] spot_color;
   } req_type;

   typedef struct packed {
      logic [5:0]  pixel_index;
      logic [23:0] pixel_color;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] color;
      logic [7:0] factor;
      logic [7:0] old;
      logic       old_nz;
   } chan_in_type;

endpackage

/* design/lssb_ram.sv */
module lssb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/lssb_chan_unit.sv */
module lssb_chan_unit (
   input  lssb_pkg::chan_in_type chan_in,
   output logic [7:0]            chan_out
);

   logic [15:0] prod;
   logic [7:0]  scaled;
   logic [8:0]  sum;

   // scale one channel by the factor, then average with the old value if the old pixel is nonzero
   assign prod = 16'(chan_in.color) * 16'(chan_in.factor);
   assign scaled = prod[15:8];
   assign sum = {1'b0, scaled} + {1'b0, chan_in.old};
   assign chan_out = chan_in.old_nz ? sum[8:1] : scaled;

endmodule

/* design/led_strip_subpixel_spot_blend.sv */
// Spot blender for an LED strip of NUM_PIXELS 24-bit pixels. A draw item places a spot of one
// color at a position in 1/255-pixel steps (clamped to 1..255*NUM_PIXELS) and emits one rsp
// item per pixel written inside the strip, lower-side pixels first going down, then upper-side
// pixels going up, the final one flagged last; a pixel that was nonzero is averaged with the
// new value per channel. The spread register widens the spot. req_stall is high while an item
// is in work: a draw runs its setup (S_DIV, then S_SPLIT), then per pixel one pixel store read,
// one pass of the shared 8x8 channel multiplier per channel and one write, for up to 10 pixels,
// one more step past the strip end when the spot sits there, plus any wait on rsp_stall.
// A clear item, and reset itself, run a pass that zeroes the pixel store one entry per cycle
// before the next item is taken.
module led_strip_subpixel_spot_blend #(
   parameter int NUM_PIXELS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lssb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lssb_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [9:0]        csr_data
);

   localparam int AW = $clog2(NUM_PIXELS);
   localparam int IW = $clog2(NUM_PIXELS + 2);
   localparam int PMAX_FULL = 255 * NUM_PIXELS;
   localparam logic [15:0] PMAX = (PMAX_FULL > 65535) ? 16'hFFFF : 16'(PMAX_FULL);
   localparam logic [IW-1:0] NP = IW'(NUM_PIXELS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PIXELS - 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_CLEAR = 7'b0000010,
      S_DIV   = 7'b0000100,
      S_SPLIT = 7'b0001000,
      S_READ  = 7'b0010000,
      S_CALC  = 7'b0100000,
      S_WRITE = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [9:0]        spread_ff, spread_in;
   logic [15:0]       pos_ff, pos_in;
   logic [23:0]       color_ff, color_in;
   logic [8:0]        quot_ff, quot_in;
   logic              upper_ff, upper_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [IW-1:0]     hi_ff, hi_in;
   logic [10:0]       int_ff, int_in;
   logic [10:0]       ub_ff, ub_in;
   logic [1:0]        ch_ff, ch_in;
   logic [23:0]       new_color_ff, new_color_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lssb_pkg::rsp_type rsp_ff, rsp_in;

   logic                  req_fire;
   logic [15:0]           pos_clamped;
   logic [25:0]           div_prod;
   logic [15:0]           quot_scaled;
   logic [15:0]           frac_full;
   logic [7:0]            frac;
   logic [9:0]            sp;
   logic [10:0]           int_dec;
   logic [7:0]            factor;
   logic                  adv_more;
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [23:0]           ram_wdata;
   logic                  ram_re;
   logic [23:0]           ram_rdata;
   logic                  wr_fire;
   lssb_pkg::chan_in_type chan_in;
   logic [7:0]            chan_out;
   logic [4:0]            ch_base;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign pos_clamped = (req_data.position == 16'd0) ? 16'd1 :
                        (req_data.position > PMAX) ? PMAX : req_data.position;

   // floor(p / 255) as ((p + 1) * 257) >> 16, exact for 16-bit p
   assign div_prod = 26'({1'b0, pos_ff} + 17'd1) * 26'(9'd257);
   assign quot_scaled = 16'({quot_ff, 8'b0} - {8'b0, quot_ff});
   assign frac_full = pos_ff - quot_scaled;
   assign frac = frac_full[7:0];
   assign sp = (spread_ff > lssb_pkg::SPREAD_MAX) ? lssb_pkg::SPREAD_MAX : spread_ff;

   assign int_dec = (int_ff > 11'(lssb_pkg::FULL_SCALE)) ?
                    int_ff - 11'(lssb_pkg::FULL_SCALE) : 11'd0;
   assign factor = (int_ff > 11'(lssb_pkg::FULL_SCALE)) ? lssb_pkg::FULL_SCALE : int_ff[7:0];

   // another pixel on the same side follows
   assign adv_more = upper_ff ? (int_ff > 11'(lssb_pkg::FULL_SCALE)) && (idx_ff + 1'b1 < NP)
                              : (idx_ff != '0) && (int_ff > 11'(lssb_pkg::FULL_SCALE));

   assign ch_base = {ch_ff, 3'b000};
   assign chan_in.color = color_ff[ch_base +: 8];
   assign chan_in.factor = factor;
   assign chan_in.old = ram_rdata[ch_base +: 8];
   assign chan_in.old_nz = (ram_rdata != 24'd0);

   assign wr_fire = (state_ff == S_WRITE) && !(rsp_valid_ff && rsp_stall);

   assign ram_we = (state_ff == S_CLEAR) || wr_fire;
   assign ram_waddr = (state_ff == S_CLEAR) ? clr_cnt_ff : idx_ff[AW-1:0];
   assign ram_wdata = (state_ff == S_CLEAR) ? 24'd0 : new_color_ff;
   assign ram_re = (state_ff == S_READ);

   always_comb begin
      state_in = state_ff;
      clr_cnt_in = clr_cnt_ff;
      spread_in = spread_ff;
      pos_in = pos_ff;
      color_in = color_ff;
      quot_in = quot_ff;
      upper_in = upper_ff;
      idx_in = idx_ff;
      hi_in = hi_ff;
      int_in = int_ff;
      ub_in = ub_ff;
      ch_in = ch_ff;
      new_color_in = new_color_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;

      if (csr_valid && csr_ready) begin
         spread_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               pos_in = pos_clamped;
               color_in = req_data.spot_color;
               clr_cnt_in = '0;
               state_in = (req_data.op == lssb_pkg::OP_CLEAR) ? S_CLEAR : S_DIV;
            end
         end
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            quot_in = div_prod[24:16];
            state_in = S_SPLIT;
         end
         S_SPLIT: begin
            upper_in = 1'b0;
            idx_in = IW'(quot_ff);
            hi_in = IW'(quot_ff) + 1'b1;
            int_in = 11'(lssb_pkg::FULL_SCALE - frac) + 11'(sp);
            ub_in = 11'(frac) + 11'(sp);
            state_in = S_READ;
         end
         S_READ: begin
            ch_in = '0;
            if (!upper_ff && idx_ff == NP) begin
               // step past the strip end: nothing stored, the intensity still drops
               if (int_ff > 11'(lssb_pkg::FULL_SCALE)) begin
                  idx_in = idx_ff - 1'b1;
                  int_in = int_dec;
               end else if (ub_ff != '0 && hi_ff < NP) begin
                  upper_in = 1'b1;
                  idx_in = hi_ff;
                  int_in = ub_ff;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            new_color_in[ch_base +: 8] = chan_out;
            ch_in = ch_ff + 1'b1;
            if (ch_ff == lssb_pkg::LAST_CH) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (wr_fire) begin
               rsp_valid_in = 1'b1;
               rsp_in.pixel_index = 6'(idx_ff);
               rsp_in.pixel_color = new_color_ff;
               if (adv_more) begin
                  rsp_in.last = 1'b0;
                  idx_in = upper_ff ? idx_ff + 1'b1 : idx_ff - 1'b1;
                  int_in = int_dec;
                  state_in = S_READ;
               end else if (!upper_ff && ub_ff != '0 && hi_ff < NP) begin
                  rsp_in.last = 1'b0;
                  upper_in = 1'b1;
                  idx_in = hi_ff;
                  int_in = ub_ff;
                  state_in = S_READ;
               end else begin
                  rsp_in.last = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_cnt_ff <= '0;
         spread_ff <= lssb_pkg::SPREAD_RESET;
         rsp_valid_ff <= 1'b0;
         upper_ff <= 1'b0;
         ch_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         spread_ff <= spread_in;
         rsp_valid_ff <= rsp_valid_in;
         upper_ff <= upper_in;
         ch_ff <= ch_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      color_ff <= color_in;
      quot_ff <= quot_in;
      idx_ff <= idx_in;
      hi_ff <= hi_in;
      int_ff <= int_in;
      ub_ff <= ub_in;
      new_color_ff <= new_color_in;
      rsp_ff <= rsp_in;
   end

   lssb_ram #(
      .WIDTH(24),
      .DEPTH(NUM_PIXELS)
   ) u_store (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re(ram_re),
      .raddr(idx_ff[AW-1:0]),
      .rdata(ram_rdata)
   );

   lssb_chan_unit u_chan (
      .chan_in(chan_in),
      .chan_out(chan_out)
   );

`ifndef SYNTHESIS
   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (wr_fire && !adv_more && !(!upper_ff && ub_ff != '0 && hi_ff < NP))
      |=> (state_ff == S_IDLE && rsp_valid_ff && rsp_ff.last))
      else $error("last pixel write did not end the item");

   a_ch_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CALC) |-> (ch_ff <= lssb_pkg::LAST_CH))
      else $error("channel counter out of range");

   a_write_in_strip: assert property (@(posedge clock) disable iff (reset)
      wr_fire |-> (idx_ff < NP))
      else $error("pixel write outside the strip");

   a_upper_in_strip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ && upper_ff) |-> (idx_ff < NP && idx_ff != '0))
      else $error("upper side index out of range");
`endif

endmodule
